// ===== sv/sfd_pkg.sv =====
// Shared types, widths and register codes for the staggered finite-difference stream.
package sfd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int SCALE_W   = 24;
    localparam int HO_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DERIV_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE = 3'd7;

    localparam logic [HO_W-1:0]    HALF_ORDER_RST = 3'd4;
    localparam logic [COEF_W-1:0]  COEF_ONE_RST   = 18'h10000;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 24'h010000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       line_start;
    } in_beat_t;

    typedef struct packed {
        logic signed [DERIV_W-1:0] derivative;
        logic                      saturated;
    } out_beat_t;

endpackage

// ===== sv/staggered_fd_derivative_stream_top.sv =====
// Top level: configuration registers, front end, snapshot queue and back end.
// A snapshot passes the queue, the MAC, MUL and DONE states and the output register.
// Back end pops only when idle; one multiply-accumulate per pair, N the effective half order.
// Beats that yield no result are taken one per cycle while the two-entry queue has room.
// Reset clears the sample window, fill count, queue and output valid flag at once.
// Registers reset to half order 4, first coefficient 1.0, other coefficients 0, scale 1.0.
module staggered_fd_derivative_stream_top #(
    parameter int MAX_HALF_ORDER = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sfd_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sfd_pkg::out_beat_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfd_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF_ORDER;
    localparam int Q_WIDTH   = WIN_DEPTH * SAMPLE_W;

    logic [HO_W-1:0]                         half_order_reg;
    logic [MAX_HALF_ORDER-1:0][COEF_W-1:0]   coef_reg;
    logic [SCALE_W-1:0]                      scale_reg;
    logic [HO_W-1:0]                         half_n;
    logic                                    cfg_write;

    logic                                    push;
    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0]      push_data;
    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0]      pop_data;
    logic                                    q_full;
    logic                                    q_valid;
    logic                                    pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (half_order_reg == '0)
        begin
            half_n = HO_W'(1);
        end
        else if (int'(half_order_reg) > MAX_HALF_ORDER)
        begin
            half_n = HO_W'(MAX_HALF_ORDER);
        end
        else
        begin
            half_n = half_order_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_order_reg <= HALF_ORDER_RST;
            coef_reg       <= (MAX_HALF_ORDER * COEF_W)'(COEF_ONE_RST);
            scale_reg      <= SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                CFG_HALF_ORDER:
                begin
                    half_order_reg <= cfg_data[HO_W-1:0];
                end
                [CFG_COEF_FIRST:CFG_COEF_LAST]:
                begin
                    for (int k = 0; k < MAX_HALF_ORDER; k++)
                    begin
                        if (int'(cfg_index) - 1 == k)
                        begin
                            coef_reg[k] <= cfg_data[COEF_W-1:0];
                        end
                    end
                end
                CFG_GRID_SCALE:
                begin
                    scale_reg <= cfg_data[SCALE_W-1:0];
                end
                default:
                begin
                    scale_reg <= scale_reg;
                end
            endcase
        end
    end

    sfd_front #(
        .MAX_HALF_ORDER(MAX_HALF_ORDER)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .half_n    (half_n),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    sfd_queue #(
        .WIDTH(Q_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (pop_data)
    );

    sfd_back #(
        .MAX_HALF_ORDER(MAX_HALF_ORDER)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .pop        (pop),
        .pop_data   (pop_data),
        .half_n     (half_n),
        .coefs      (coef_reg),
        .grid_scale (scale_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== sv/sfd_front.sv =====
// Input side: sample window, line fill count and classification of each beat.
module sfd_front #(
    parameter int MAX_HALF_ORDER = 6
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  sfd_pkg::in_beat_t                                  in_data,
    input  logic [sfd_pkg::HO_W-1:0]                           half_n,
    input  logic                                               q_full,
    output logic                                               push,
    output logic [2*MAX_HALF_ORDER-1:0][sfd_pkg::SAMPLE_W-1:0] push_data
);
    import sfd_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF_ORDER;
    localparam int FC_W      = $clog2(WIN_DEPTH + 1);

    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win_reg;
    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win_next;
    logic [FC_W-1:0]                    fc_reg;
    logic [FC_W-1:0]                    fc_base;
    logic [FC_W-1:0]                    fc_next;
    logic [FC_W-1:0]                    two_n;
    logic                               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign two_n    = FC_W'({half_n, 1'b0});

    always_comb
    begin
        win_next[0] = in_data.sample;
        for (int k = 1; k < WIN_DEPTH; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        fc_base = in_data.line_start ? '0 : fc_reg;
        fc_next = (fc_base < FC_W'(WIN_DEPTH)) ? fc_base + FC_W'(1) : fc_base;
    end

    assign push      = accept && (fc_next >= two_n);
    assign push_data = win_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            fc_reg  <= '0;
        end
        else if (accept)
        begin
            win_reg <= win_next;
            fc_reg  <= fc_next;
        end
    end

endmodule

// ===== sv/sfd_queue.sv =====
// Two-entry queue that carries window snapshots from the front to the back.
module sfd_queue #(
    parameter int WIDTH = 288
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import sfd_pkg::*;

    logic [1:0][WIDTH-1:0] entry_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("Queue read while empty.");

endmodule

// ===== sv/sfd_back.sv =====
// Execution side: shared multiply-accumulate over the stencil, scaling, rounding, saturation and output register.
module sfd_back #(
    parameter int MAX_HALF_ORDER = 6
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               q_valid,
    output logic                                               pop,
    input  logic [2*MAX_HALF_ORDER-1:0][sfd_pkg::SAMPLE_W-1:0] pop_data,
    input  logic [sfd_pkg::HO_W-1:0]                           half_n,
    input  logic [MAX_HALF_ORDER-1:0][sfd_pkg::COEF_W-1:0]     coefs,
    input  logic [sfd_pkg::SCALE_W-1:0]                        grid_scale,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output sfd_pkg::out_beat_t                                 out_data
);
    import sfd_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF_ORDER;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int CI_W      = (MAX_HALF_ORDER > 1) ? $clog2(MAX_HALF_ORDER) : 1;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_HALF_ORDER);
    localparam int LO_W      = ACC_W / 2;
    localparam int HI_W      = ACC_W - LO_W;
    localparam int PLO_W     = LO_W + SCALE_W;
    localparam int PHI_W     = HI_W + SCALE_W + 1;
    localparam int P_W       = ACC_W + SCALE_W + 2;
    localparam int RES_HI_W  = P_W - (DERIV_W + 31);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] a_reg;
    logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] b_reg;
    logic [CI_W-1:0]                    ci_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic [PLO_W-1:0]                   plo_reg;
    logic signed [PHI_W-1:0]            phi_reg;
    logic                               out_valid_reg;
    out_beat_t                          out_data_reg;

    logic [WIN_IDX_W-1:0]               b_idx;
    sample_t                            a_head;
    sample_t                            b_sel;
    coef_t                              coef_sel;
    logic signed [DIFF_W-1:0]           diff;
    logic signed [PROD_W-1:0]           prod;
    logic [LO_W-1:0]                    acc_lo;
    logic signed [HI_W-1:0]             acc_hi;
    logic signed [SCALE_W:0]            scale_s;
    logic signed [P_W-1:0]              total;
    logic [RES_HI_W-1:0]                res_hi;
    logic                               sat;
    logic                               out_free;
    out_beat_t                          result;

    assign b_idx    = WIN_IDX_W'({1'b0, half_n, 1'b0} - 5'd1);
    assign a_head   = a_reg[0];
    assign b_sel    = b_reg[b_idx];
    assign coef_sel = coefs[ci_reg];
    assign diff     = DIFF_W'(a_head) - DIFF_W'(b_sel);
    assign prod     = diff * coef_sel;

    assign acc_lo   = acc_reg[LO_W-1:0];
    assign acc_hi   = acc_reg[ACC_W-1:LO_W];
    assign scale_s  = signed'({1'b0, grid_scale});

    assign total    = (P_W'(phi_reg) <<< LO_W) + signed'(P_W'(plo_reg))
                      + signed'(P_W'(64'h8000_0000));
    assign res_hi   = total[P_W-1:DERIV_W+31];
    assign sat      = !((&res_hi) || !(|res_hi));

    always_comb
    begin
        result.saturated = sat;
        if (sat)
        begin
            result.derivative = total[P_W-1] ? {1'b1, {(DERIV_W-1){1'b0}}}
                                             : {1'b0, {(DERIV_W-1){1'b1}}};
        end
        else
        begin
            result.derivative = total[DERIV_W+31:32];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (ci_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_reg   <= pop_data;
            b_reg   <= pop_data;
            acc_reg <= '0;
            ci_reg  <= CI_W'(half_n - HO_W'(1));
        end
        else if (state_reg == ST_MAC)
        begin
            for (int k = 0; k < WIN_DEPTH - 1; k++)
            begin
                a_reg[k] <= a_reg[k+1];
            end
            for (int k = 1; k < WIN_DEPTH; k++)
            begin
                b_reg[k] <= b_reg[k-1];
            end
            acc_reg <= acc_reg + ACC_W'(prod);
            ci_reg  <= ci_reg - CI_W'(1);
        end
        if (state_reg == ST_MUL)
        begin
            plo_reg <= PLO_W'(acc_lo) * PLO_W'(grid_scale);
            phi_reg <= PHI_W'(acc_hi) * PHI_W'(scale_s);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_MAC)
        else $error("Queue popped without starting the accumulation.");

    a_mac_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && ci_reg == '0) |=> state_reg == ST_MUL)
        else $error("Accumulation did not stop after the last coefficient.");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> state_reg == ST_DONE)
        else $error("Result left the back end while the output beat was stalled.");

endmodule
